### design/rpcf_pkg.sv
package rpcf_pkg;

    // Default geometry of the cache.
    localparam int CHUNK_BYTES_DEF = 4096;
    localparam int NUM_SLOTS_DEF   = 64;
    localparam int NUM_CHUNKS_DEF  = 8192;

    // Stream widths, wide enough for the request and result fields.
    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 72;

    // Opcode carried in s_tuser.
    localparam logic OP_MAP_WRITE = 1'b0;
    localparam logic OP_LOOKUP    = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK,
        ST_EVICT,
        ST_RESP
    } state_t;

    typedef enum logic [1:0] {
        OUT_NONE,
        OUT_LOOK,
        OUT_STAGE,
        OUT_ZERO
    } out_sel_t;

    typedef struct packed {
        logic     clear_write;
        logic     map_write;
        logic     lookup;
        logic     capture;
        logic     commit;
        logic     evict_write;
        logic     stage_zero;
        out_sel_t out_sel;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
        logic hit;
        logic victim_valid;
        logic out_free;
    } sts_t;

    typedef struct packed {
        logic [12:0] evicted_chunk;
        logic        evicted_valid;
        logic [31:0] fill_sector;
        logic        fill_request;
        logic [11:0] offset;
        logic [5:0]  slot;
        logic        hit;
    } result_t;

endpackage

### design/rom_page_cache_fifo_unit.sv
// Demand-paged chunk cache for a ROM image with round-robin slot replacement.
// A request with opcode 0 stores the first disk sector of one chunk in the
// sector map; a chunk index at or beyond NUM_CHUNKS is ignored, and the result
// is all zeros. A request with opcode 1 splits a byte position into a chunk
// index (wrapped to NUM_CHUNKS) and an offset. On a hit the result names the
// slot that holds the chunk. On a miss the chunk that owns the slot under the
// replacement pointer is unmapped and reported, the new chunk takes that slot,
// a fill request carries the chunk's mapped sector, and the pointer advances
// with wrap. Every request gives exactly one result. A miss that evicts a chunk
// passes through ST_EVICT after ST_LOOK, because the residency memory has one
// write port and must both map the new chunk and unmap the victim. After reset
// the block clears every entry of the residency memory and takes no request
// until that pass ends. CHUNK_BYTES and NUM_CHUNKS must be powers of two.
module rom_page_cache_fifo_unit #(
    parameter int CHUNK_BYTES = rpcf_pkg::CHUNK_BYTES_DEF,
    parameter int NUM_SLOTS   = rpcf_pkg::NUM_SLOTS_DEF,
    parameter int NUM_CHUNKS  = rpcf_pkg::NUM_CHUNKS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // Fields from bit 0: position[24:0], map_chunk[37:25], map_sector[69:38].
    input  logic [rpcf_pkg::S_TDATA_W-1:0] s_tdata,
    // Fields from bit 0: opcode[0].
    input  logic [0:0]                     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // Fields from bit 0: hit[0], slot[6:1], offset[18:7], fill_request[19],
    // fill_sector[51:20], evicted_valid[52], evicted_chunk[65:53].
    output logic [rpcf_pkg::M_TDATA_W-1:0] m_tdata
);
    import rpcf_pkg::*;

    // The controller sequences each request; the datapath holds the memories,
    // the slot pointer, the owner valid bits and the result register.
    cmd_t cmd;
    sts_t sts;

    rpcf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .opcode   (s_tuser[0]),
        .sts      (sts),
        .cmd      (cmd)
    );

    rpcf_datapath #(
        .CHUNK_BYTES (CHUNK_BYTES),
        .NUM_SLOTS   (NUM_SLOTS),
        .NUM_CHUNKS  (NUM_CHUNKS)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .sts      (sts),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

### design/rpcf_ram.sv
module rpcf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

### design/rpcf_ctrl.sv
module rpcf_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic           opcode,
    input  rpcf_pkg::sts_t sts,
    output rpcf_pkg::cmd_t cmd
);
    import rpcf_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (sts.clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    if (opcode == OP_LOOKUP) begin
                        state_next = ST_LOOK;
                    end else if (!sts.out_free) begin
                        state_next = ST_RESP;
                    end
                end
            end
            ST_LOOK: begin
                if (!sts.hit && sts.victim_valid) begin
                    state_next = ST_EVICT;
                end else if (sts.out_free) begin
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_RESP;
                end
            end
            ST_EVICT: begin
                state_next = sts.out_free ? ST_IDLE : ST_RESP;
            end
            ST_RESP: begin
                if (sts.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd = '0;
        cmd.out_sel = OUT_NONE;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clear_write = 1'b1;
            end
            ST_IDLE: begin
                if (accept) begin
                    if (opcode == OP_LOOKUP) begin
                        cmd.lookup = 1'b1;
                    end else begin
                        cmd.map_write = 1'b1;
                        if (sts.out_free) begin
                            cmd.out_sel = OUT_ZERO;
                        end else begin
                            cmd.stage_zero = 1'b1;
                        end
                    end
                end
            end
            ST_LOOK: begin
                cmd.capture = 1'b1;
                cmd.commit  = !sts.hit;
                if ((sts.hit || !sts.victim_valid) && sts.out_free) begin
                    cmd.out_sel = OUT_LOOK;
                end
            end
            ST_EVICT: begin
                cmd.evict_write = 1'b1;
                if (sts.out_free) begin
                    cmd.out_sel = OUT_STAGE;
                end
            end
            ST_RESP: begin
                if (sts.out_free) begin
                    cmd.out_sel = OUT_STAGE;
                end
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

### design/rpcf_datapath.sv
module rpcf_datapath #(
    parameter int CHUNK_BYTES = rpcf_pkg::CHUNK_BYTES_DEF,
    parameter int NUM_SLOTS   = rpcf_pkg::NUM_SLOTS_DEF,
    parameter int NUM_CHUNKS  = rpcf_pkg::NUM_CHUNKS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [rpcf_pkg::S_TDATA_W-1:0]  s_tdata,
    input  rpcf_pkg::cmd_t                  cmd,
    output rpcf_pkg::sts_t                  sts,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [rpcf_pkg::M_TDATA_W-1:0]  m_tdata
);
    import rpcf_pkg::*;

    localparam int CB_W    = $clog2(CHUNK_BYTES);
    localparam int CHUNK_W = $clog2(NUM_CHUNKS);
    localparam int SLOT_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int RES_W   = SLOT_W + 1;

    // Request fields.
    logic [24:0] in_pos;
    logic [12:0] in_map_chunk;
    logic [31:0] in_map_sector;

    assign in_pos        = s_tdata[24:0];
    assign in_map_chunk  = s_tdata[37:25];
    assign in_map_sector = s_tdata[69:38];

    logic [24:0]        pos_quot;
    logic [24:0]        pos_off;
    logic [CHUNK_W-1:0] lk_chunk;
    logic [15:0]        map_chunk16;
    logic               map_in_range;

    assign pos_quot     = in_pos >> CB_W;
    assign pos_off      = in_pos & ((25'd1 << CB_W) - 25'd1);
    assign lk_chunk     = pos_quot[CHUNK_W-1:0];
    assign map_chunk16  = 16'(in_map_chunk);
    assign map_in_range = 17'(in_map_chunk) < 17'(NUM_CHUNKS);

    // Registers.
    logic [CHUNK_W-1:0]   chunk_reg;
    logic [11:0]          offset_reg;
    logic [CHUNK_W-1:0]   victim_reg;
    logic [SLOT_W-1:0]    next_slot_reg;
    logic [SLOT_W-1:0]    next_slot_next;
    logic [NUM_SLOTS-1:0] owner_valid_reg;
    logic [CHUNK_W-1:0]   clr_cnt_reg;
    result_t              stage_reg;
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    // Memories.
    logic               res_we;
    logic [CHUNK_W-1:0] res_waddr;
    logic [RES_W-1:0]   res_wdata;
    logic [RES_W-1:0]   res_rdata;
    logic [31:0]        sec_rdata;
    logic [CHUNK_W-1:0] own_rdata;

    always_comb begin
        res_we    = 1'b0;
        res_waddr = chunk_reg;
        res_wdata = '0;
        if (cmd.clear_write) begin
            res_we    = 1'b1;
            res_waddr = clr_cnt_reg;
        end else if (cmd.commit) begin
            res_we    = 1'b1;
            res_waddr = chunk_reg;
            res_wdata = {1'b1, next_slot_reg};
        end else if (cmd.evict_write) begin
            res_we    = 1'b1;
            res_waddr = victim_reg;
        end
    end

    rpcf_ram #(.WIDTH(RES_W), .DEPTH(NUM_CHUNKS)) u_res_ram (
        .clk   (aclk),
        .we    (res_we),
        .waddr (res_waddr),
        .wdata (res_wdata),
        .re    (cmd.lookup),
        .raddr (lk_chunk),
        .rdata (res_rdata)
    );

    rpcf_ram #(.WIDTH(32), .DEPTH(NUM_CHUNKS)) u_sec_ram (
        .clk   (aclk),
        .we    (cmd.map_write && map_in_range),
        .waddr (map_chunk16[CHUNK_W-1:0]),
        .wdata (in_map_sector),
        .re    (cmd.lookup),
        .raddr (lk_chunk),
        .rdata (sec_rdata)
    );

    rpcf_ram #(.WIDTH(CHUNK_W), .DEPTH(NUM_SLOTS)) u_own_ram (
        .clk   (aclk),
        .we    (cmd.commit),
        .waddr (next_slot_reg),
        .wdata (chunk_reg),
        .re    (cmd.lookup),
        .raddr (next_slot_reg),
        .rdata (own_rdata)
    );

    // Lookup decision, valid in the cycle after the request was taken.
    logic              look_hit;
    logic              look_victim;
    logic [SLOT_W-1:0] look_slot;
    logic [9:0]        look_slot10;
    logic [15:0]       victim16;
    result_t           look_res;

    assign look_hit    = res_rdata[SLOT_W];
    assign look_victim = owner_valid_reg[next_slot_reg];
    assign look_slot   = look_hit ? res_rdata[SLOT_W-1:0] : next_slot_reg;
    assign look_slot10 = 10'(look_slot);
    assign victim16    = 16'(own_rdata);

    always_comb begin
        look_res               = '0;
        look_res.hit           = look_hit;
        look_res.slot          = look_slot10[5:0];
        look_res.offset        = offset_reg;
        look_res.fill_request  = !look_hit;
        look_res.fill_sector   = look_hit ? 32'd0 : sec_rdata;
        look_res.evicted_valid = !look_hit && look_victim;
        look_res.evicted_chunk = (!look_hit && look_victim) ? victim16[12:0] : 13'd0;
    end

    assign next_slot_next = (32'(next_slot_reg) == NUM_SLOTS - 1) ? '0
                                                                 : next_slot_reg + 1'b1;

    assign sts.clear_last   = (clr_cnt_reg == CHUNK_W'(NUM_CHUNKS - 1));
    assign sts.hit          = look_hit;
    assign sts.victim_valid = look_victim;
    assign sts.out_free     = !m_tvalid_reg || m_tready;

    function automatic logic [M_TDATA_W-1:0] pack_result(input result_t r);
        pack_result = {6'd0, r.evicted_chunk, r.evicted_valid, r.fill_sector,
                       r.fill_request, r.offset, r.slot, r.hit};
    endfunction

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            next_slot_reg   <= '0;
            owner_valid_reg <= '0;
            clr_cnt_reg     <= '0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            if (cmd.clear_write) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cmd.commit) begin
                owner_valid_reg[next_slot_reg] <= 1'b1;
                next_slot_reg                  <= next_slot_next;
            end
            if (cmd.out_sel != OUT_NONE) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload.
    always_ff @(posedge aclk) begin
        if (cmd.lookup) begin
            chunk_reg  <= lk_chunk;
            offset_reg <= pos_off[11:0];
        end
        if (cmd.capture) begin
            victim_reg <= own_rdata;
            stage_reg  <= look_res;
        end else if (cmd.stage_zero) begin
            stage_reg  <= '0;
        end
        case (cmd.out_sel)
            OUT_LOOK:  m_tdata_reg <= pack_result(look_res);
            OUT_STAGE: m_tdata_reg <= pack_result(stage_reg);
            OUT_ZERO:  m_tdata_reg <= '0;
            default:   m_tdata_reg <= m_tdata_reg;
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
